[hdl/malu_pkg.sv]
// ----------------------------------------------------------------------------
// malu_pkg
// Shared types and constants for the ALU with HI/LO multiply and divide.
// ----------------------------------------------------------------------------
package malu_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CMD_W   = 4;
	localparam int unsigned ITER_N  = WORD_W;
	localparam int unsigned CNT_W   = $clog2(ITER_N);

	typedef enum logic [CMD_W-1:0] {
		CMD_AND   = 4'd0,
		CMD_OR    = 4'd1,
		CMD_ADD   = 4'd2,
		CMD_DIV   = 4'd3,
		CMD_MULT  = 4'd4,
		CMD_SUB   = 4'd6,
		CMD_SLT   = 4'd7,
		CMD_SETHI = 4'd8,
		CMD_SETLO = 4'd9,
		CMD_NOR   = 4'd12
	} opcode_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic init;
		logic step;
		logic fix;
		logic commit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic iterative;
	} dp_status_t;

endpackage

[hdl/malu_in_if.sv]
// ----------------------------------------------------------------------------
// malu_in_if
// Operation channel: command code and two signed operands.
// ----------------------------------------------------------------------------
interface malu_in_if import malu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [WORD_W-1:0] operand_a;
	logic signed [WORD_W-1:0] operand_b;

	modport source (output valid, cmd, operand_a, operand_b, input ready);
	modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

[hdl/malu_out_if.sv]
// ----------------------------------------------------------------------------
// malu_out_if
// Result channel: result register, flags, HI, LO and divide error.
// ----------------------------------------------------------------------------
interface malu_out_if import malu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] result;
	logic                     zero;
	logic                     carry;
	logic                     overflow;
	logic signed [WORD_W-1:0] hi_value;
	logic signed [WORD_W-1:0] lo_value;
	logic                     divide_by_zero;

	modport source (output valid, result, zero, carry, overflow, hi_value, lo_value,
		divide_by_zero, input ready);
	modport sink   (input valid, result, zero, carry, overflow, hi_value, lo_value,
		divide_by_zero, output ready);
endinterface

[hdl/malu_ctrl.sv]
// ----------------------------------------------------------------------------
// malu_ctrl
// Sequencer: decode, 32-step multiply/divide loop, sign fixup, commit.
// ----------------------------------------------------------------------------
module malu_ctrl import malu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ITER,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.init   = (state_q == ST_DECODE) && status.iterative;
		cmd.step   = (state_q == ST_ITER);
		cmd.fix    = (state_q == ST_FIX);
		cmd.commit = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					cnt_q   <= '0;
					state_q <= status.iterative ? ST_ITER : ST_DONE;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ITER_N - 1))
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/malu_dp.sv]
// ----------------------------------------------------------------------------
// malu_dp
// Datapath: operand latch, shift-add / restoring loop, HI/LO and result
// registers, output word register.
// ----------------------------------------------------------------------------
module malu_dp import malu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_cmd_t                 cmd,
	output dp_status_t               status,
	input  logic [CMD_W-1:0]         in_cmd,
	input  logic signed [WORD_W-1:0] in_a,
	input  logic signed [WORD_W-1:0] in_b,
	output logic signed [WORD_W-1:0] o_result,
	output logic                     o_zero,
	output logic                     o_carry,
	output logic                     o_overflow,
	output logic signed [WORD_W-1:0] o_hi,
	output logic signed [WORD_W-1:0] o_lo,
	output logic                     o_dz
);

	logic [CMD_W-1:0]    op_q;
	logic [WORD_W-1:0]   a_q, b_q, mb_q;
	logic [2*WORD_W-1:0] acc_q;

	logic [WORD_W-1:0]   result_q, hi_q, lo_q;
	logic                zero_q, carry_q, ovf_q;

	logic [WORD_W-1:0]   a_mag, b_mag;
	logic                b_is_zero, is_mul, is_div;
	logic [WORD_W:0]     mul_sum;
	logic [WORD_W+1:0]   div_diff;
	logic [2*WORD_W-1:0] acc_step, acc_fix;
	logic [WORD_W-1:0]   rem_abs, quo_abs;

	logic [WORD_W:0]     add_w, sub_w;
	logic [WORD_W-1:0]   result_d, hi_d, lo_d;
	logic                zero_d, carry_d, ovf_d, dz_d;

	assign a_mag     = a_q[WORD_W-1] ? (~a_q + 1'b1) : a_q;
	assign b_mag     = b_q[WORD_W-1] ? (~b_q + 1'b1) : b_q;
	assign b_is_zero = (b_q == '0);
	assign is_mul    = (op_q == CMD_MULT);
	assign is_div    = (op_q == CMD_DIV);

	assign status.iterative = is_mul || (is_div && !b_is_zero);

	// one loop step
	always_comb begin
		mul_sum  = {1'b0, acc_q[2*WORD_W-1:WORD_W]} + (acc_q[0] ? {1'b0, mb_q} : '0);
		div_diff = {1'b0, acc_q[2*WORD_W-1:WORD_W-1]} - {2'b00, mb_q};
		if (is_mul)
			acc_step = {mul_sum, acc_q[WORD_W-1:1]};
		else if (!div_diff[WORD_W+1])
			acc_step = {div_diff[WORD_W-1:0], acc_q[WORD_W-2:0], 1'b1};
		else
			acc_step = {acc_q[2*WORD_W-2:0], 1'b0};
	end

	// sign fixup
	always_comb begin
		rem_abs = acc_q[2*WORD_W-1:WORD_W];
		quo_abs = acc_q[WORD_W-1:0];
		if (is_mul)
			acc_fix = (a_q[WORD_W-1] ^ b_q[WORD_W-1]) ? (~acc_q + 1'b1) : acc_q;
		else
			acc_fix = {a_q[WORD_W-1] ? (~rem_abs + 1'b1) : rem_abs,
				(a_q[WORD_W-1] ^ b_q[WORD_W-1]) ? (~quo_abs + 1'b1) : quo_abs};
	end

	// next architectural state
	always_comb begin
		add_w    = {1'b0, a_q} + {1'b0, b_q};
		sub_w    = {1'b0, a_q} - {1'b0, b_q};
		result_d = result_q;
		hi_d     = hi_q;
		lo_d     = lo_q;
		zero_d   = zero_q;
		carry_d  = carry_q;
		ovf_d    = ovf_q;
		dz_d     = 1'b0;
		case (op_q)
			CMD_AND: begin
				result_d = a_q & b_q;
				carry_d  = 1'b0;
				ovf_d    = 1'b0;
				zero_d   = (result_d == '0);
			end
			CMD_OR: begin
				result_d = a_q | b_q;
				carry_d  = 1'b0;
				ovf_d    = 1'b0;
				zero_d   = (result_d == '0);
			end
			CMD_NOR: begin
				result_d = ~(a_q | b_q);
				carry_d  = 1'b0;
				ovf_d    = 1'b0;
				zero_d   = (result_d == '0);
			end
			CMD_SLT: begin
				result_d = WORD_W'(($signed(a_q) < $signed(b_q)) ? 1 : 0);
				carry_d  = 1'b0;
				ovf_d    = 1'b0;
				zero_d   = (result_d == '0);
			end
			CMD_ADD: begin
				result_d = add_w[WORD_W-1:0];
				carry_d  = add_w[WORD_W];
				ovf_d    = (a_q[WORD_W-1] == b_q[WORD_W-1]) &&
					(add_w[WORD_W-1] != a_q[WORD_W-1]);
				zero_d   = (result_d == '0);
			end
			CMD_SUB: begin
				result_d = sub_w[WORD_W-1:0];
				carry_d  = sub_w[WORD_W];
				ovf_d    = (a_q[WORD_W-1] != b_q[WORD_W-1]) &&
					(sub_w[WORD_W-1] != a_q[WORD_W-1]);
				zero_d   = (result_d == '0);
			end
			CMD_MULT: begin
				hi_d    = acc_q[2*WORD_W-1:WORD_W];
				lo_d    = acc_q[WORD_W-1:0];
				zero_d  = (acc_q == '0);
				carry_d = 1'b0;
				ovf_d   = 1'b0;
			end
			CMD_DIV: begin
				if (b_is_zero) begin
					dz_d = 1'b1;
				end else begin
					hi_d    = acc_q[2*WORD_W-1:WORD_W];
					lo_d    = acc_q[WORD_W-1:0];
					zero_d  = (acc_q[WORD_W-1:0] == '0);
					carry_d = 1'b0;
					ovf_d   = 1'b0;
				end
			end
			CMD_SETHI: begin
				hi_d = a_q;
			end
			CMD_SETLO: begin
				lo_d = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			zero_q   <= 1'b0;
			carry_q  <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (cmd.commit) begin
			result_q <= result_d;
			hi_q     <= hi_d;
			lo_q     <= lo_d;
			zero_q   <= zero_d;
			carry_q  <= carry_d;
			ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_cmd;
			a_q  <= in_a;
			b_q  <= in_b;
		end
		if (cmd.init) begin
			acc_q <= {{WORD_W{1'b0}}, a_mag};
			mb_q  <= b_mag;
		end else if (cmd.step) begin
			acc_q <= acc_step;
		end else if (cmd.fix) begin
			acc_q <= acc_fix;
		end
		if (cmd.commit) begin
			o_result   <= result_d;
			o_zero     <= zero_d;
			o_carry    <= carry_d;
			o_overflow <= ovf_d;
			o_hi       <= hi_d;
			o_lo       <= lo_d;
			o_dz       <= dz_d;
		end
	end

endmodule

[hdl/mips_alu_hi_lo.sv]
// ----------------------------------------------------------------------------
// mips_alu_hi_lo
// 32-bit ALU with HI/LO registers, iterative signed multiply and divide.
//
//   channel  dir  payload
//   op       in   cmd[3:0], operand_a[31:0], operand_b[31:0]
//   res      out  result, zero, carry, overflow, hi_value, lo_value,
//                 divide_by_zero
//
// Logic, add, sub, slt, set hi/lo, div by zero and unknown codes: accept, decode, commit.
// MULT and DIV: accept, decode, the 32-step shift-add / restoring loop,
// sign fixup and commit.
// One word in flight; res holds its word while the next op is taken.
// Commit waits while the previous res word has not been taken.
// Reset clears the internal result, flags, HI and LO; the res payload is not reset.
// ----------------------------------------------------------------------------
module mips_alu_hi_lo import malu_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	malu_in_if.sink    op,
	malu_out_if.source res
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	malu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op.valid),
		.in_ready  (op.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	malu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_cmd     (op.cmd),
		.in_a       (op.operand_a),
		.in_b       (op.operand_b),
		.o_result   (res.result),
		.o_zero     (res.zero),
		.o_carry    (res.carry),
		.o_overflow (res.overflow),
		.o_hi       (res.hi_value),
		.o_lo       (res.lo_value),
		.o_dz       (res.divide_by_zero)
	);

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!res.valid || res.ready))
		else $error("commit while result word still pending");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res.valid)
		else $error("committed word not presented");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(op.valid && op.ready) |=> !op.ready)
		else $error("op taken while previous word in flight");

	a_step_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.fix) |-> status.iterative)
		else $error("loop running for a non-iterative op");

endmodule
